### src/sbda_pkg.sv
// ----------------------------------------------------------------------------
// sbda_pkg
// types and constants shared by the binary to decimal ascii converter
// ----------------------------------------------------------------------------
package sbda_pkg;

    localparam int VALUE_W = 64;
    localparam int CHAR_W  = 6;

    localparam logic [CHAR_W-1:0] CODE_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] CODE_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CODE_NINE  = 6'd57;

    localparam logic [3:0] BCD_LIMIT  = 4'd5;
    localparam logic [3:0] BCD_ADJUST = 4'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic dabble;
        logic drop_digit;
        logic emit_sign;
        logic emit_digit;
        logic last;
    } t_cmd;

    typedef struct packed {
        logic negative;
        logic top_zero;
        logic out_free;
    } t_status;

endpackage

### src/sbda_ctrl.sv
// ----------------------------------------------------------------------------
// sbda_ctrl
// sequencer: conversion steps, leading zero skip and character emission
// ----------------------------------------------------------------------------
module sbda_ctrl
    import sbda_pkg::*;
#(
    parameter int VALUE_BITS = 64,
    parameter int NDIG       = 19
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam int CNT_W = $clog2(VALUE_BITS);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = CNT_W'(VALUE_BITS - 1);
                    n_state    = ST_CONVERT;
                end
            end
            ST_CONVERT: begin
                o_cmd.dabble = 1'b1;
                if (r_cnt == '0) begin
                    n_cnt   = CNT_W'(NDIG - 1);
                    n_state = ST_SKIP;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_SKIP: begin
                if (i_status.top_zero && r_cnt != '0) begin
                    o_cmd.drop_digit = 1'b1;
                    n_cnt            = r_cnt - 1'b1;
                end else begin
                    n_state = i_status.negative ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (i_status.out_free) begin
                    o_cmd.emit_sign = 1'b1;
                    n_state         = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_digit = 1'b1;
                    o_cmd.last       = (r_cnt == '0);
                    if (r_cnt == '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_cnt = r_cnt - 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

### src/sbda_datapath.sv
// ----------------------------------------------------------------------------
// sbda_datapath
// magnitude and shift-and-add-3 registers, digit shifter, output register
// ----------------------------------------------------------------------------
module sbda_datapath
    import sbda_pkg::*;
#(
    parameter int VALUE_BITS = 64,
    parameter int NDIG       = 19
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic [VALUE_W-1:0] i_value,
    input  logic               i_out_stall,
    output t_status            o_status,
    output logic [CHAR_W-1:0]  o_char_code,
    output logic               o_last,
    output logic               o_valid
);

    localparam int BCD_W = 4 * NDIG;

    logic [VALUE_BITS-1:0] r_bin, n_bin;
    logic [BCD_W-1:0]      r_bcd, n_bcd;
    logic                  r_neg, n_neg;
    logic [CHAR_W-1:0]     r_char, n_char;
    logic                  r_last, n_last;
    logic                  r_out_valid, n_out_valid;

    logic [VALUE_BITS-1:0] v_low;
    logic [BCD_W-1:0]      bcd_adj;
    logic                  out_free;

    assign v_low    = i_value[VALUE_BITS-1:0];
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        for (int d = 0; d < NDIG; d++) begin
            if (r_bcd[4*d +: 4] >= BCD_LIMIT) begin
                bcd_adj[4*d +: 4] = r_bcd[4*d +: 4] + BCD_ADJUST;
            end else begin
                bcd_adj[4*d +: 4] = r_bcd[4*d +: 4];
            end
        end
    end

    always_comb begin
        n_bin       = r_bin;
        n_bcd       = r_bcd;
        n_neg       = r_neg;
        n_char      = r_char;
        n_last      = r_last;
        n_out_valid = r_out_valid && i_out_stall;
        if (i_cmd.load) begin
            n_neg = v_low[VALUE_BITS-1];
            n_bin = v_low[VALUE_BITS-1] ? (~v_low + 1'b1) : v_low;
            n_bcd = '0;
        end
        if (i_cmd.dabble) begin
            n_bcd = {bcd_adj[BCD_W-2:0], r_bin[VALUE_BITS-1]};
            n_bin = {r_bin[VALUE_BITS-2:0], 1'b0};
        end
        if (i_cmd.drop_digit || i_cmd.emit_digit) begin
            n_bcd = {r_bcd[BCD_W-5:0], 4'd0};
        end
        if (i_cmd.emit_sign) begin
            n_char      = CODE_MINUS;
            n_last      = 1'b0;
            n_out_valid = 1'b1;
        end
        if (i_cmd.emit_digit) begin
            n_char      = CODE_ZERO + {2'b00, r_bcd[BCD_W-1 -: 4]};
            n_last      = i_cmd.last;
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_neg  <= n_neg;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_status.negative = r_neg;
    assign o_status.top_zero = (r_bcd[BCD_W-1 -: 4] == 4'd0);
    assign o_status.out_free = out_free;

    assign o_char_code = r_char;
    assign o_last      = r_last;
    assign o_valid     = r_out_valid;

endmodule

### src/signed_binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii
// signed two's complement integer to decimal ascii text, one char per request
// ----------------------------------------------------------------------------
// input channel: i_valid / o_stall carry i_value; only the low VALUE_BITS
// bits are used, bit VALUE_BITS-1 being the sign. one value is taken while
// the block is idle; o_stall stays high until its last character is queued.
// output channel: o_valid / i_stall carry o_char_code and o_last, one
// character per request, most significant first, leading '-' for negative
// values, no leading zeros, o_last on the final character.
// the sequence is a load, the shift-and-add-3 conversion of the VALUE_BITS bits,
// the leading zeros dropped, a step to leave the zero skip, the sign for a
// negative value, then the digits emitted; drops and digits together make
// NDIG steps. the first character is registered later for shorter text.
// a stalled receiver freezes the output register and the sequencer waits.
// reset (synchronous, active low) drops o_valid and returns to idle.
// ----------------------------------------------------------------------------
module signed_binary_to_decimal_ascii
    import sbda_pkg::*;
#(
    parameter int VALUE_BITS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [CHAR_W-1:0]  o_char_code,
    output logic               o_last
);

    localparam int NDIG = ((VALUE_BITS - 1) * 30103) / 100000 + 1;

    t_cmd    cmd;
    t_status status;

    sbda_ctrl #(
        .VALUE_BITS (VALUE_BITS),
        .NDIG       (NDIG)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_stall (o_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    sbda_datapath #(
        .VALUE_BITS (VALUE_BITS),
        .NDIG       (NDIG)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_value     (i_value),
        .i_out_stall (i_stall),
        .o_status    (status),
        .o_char_code (o_char_code),
        .o_last      (o_last),
        .o_valid     (o_valid)
    );

    a_busy_after_request: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall
    ) else $error("block not busy after taking a request");

    a_sign_not_last: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_char_code == CODE_MINUS) |-> !o_last
    ) else $error("minus sign flagged as last character");

    a_char_legal: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_char_code == CODE_MINUS ||
                     (o_char_code >= CODE_ZERO && o_char_code <= CODE_NINE))
    ) else $error("illegal character code");

    a_single_load: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> (!cmd.emit_digit && !cmd.emit_sign && !cmd.dabble)
    ) else $error("load overlaps another datapath command");

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// checks signed_binary_to_decimal_ascii against a decimal text predictor
// ----------------------------------------------------------------------------
// directed table of typed text and predicted values, then random values
// sender in bursts, receiver stall patterns and one long hold-off
// ----------------------------------------------------------------------------
module testbench
    import sbda_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIR_N            = 22;
    localparam int RANDOM_VALUES    = 280;
    localparam int DIGITS_MAX       = 19;
    localparam int LONG_HOLD_CYCLES = 600;
    localparam int DRAIN_CYCLES     = 120;
    localparam int CYCLE_LIMIT      = 600000;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_ascii_char;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [VALUE_W-1:0] i_value;
    logic               o_valid;
    logic               i_stall;
    logic [CHAR_W-1:0]  o_char_code;
    logic               o_last;

    t_ascii_char        expected_chars [$];
    t_ascii_char        want_char;
    logic [VALUE_W-1:0] dir_value [DIR_N];
    string              dir_text [DIR_N];
    int                 error_count    = 0;
    int                 values_taken   = 0;
    int                 burst_left     = 0;
    int                 cycle_count    = 0;
    bit                 long_hold_done = 1'b0;

    signed_binary_to_decimal_ascii u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        error_count++;
    endtask

    function automatic logic [VALUE_W-1:0] power_of_ten(input int k);
        logic [VALUE_W-1:0] p;
        p = 1;
        for (int i = 0; i < k; i++) begin
            p = p * 10;
        end
        return p;
    endfunction

    // sign, then digits most significant first; magnitude taken unsigned
    task automatic queue_decimal_chars(input logic [VALUE_W-1:0] value);
        logic [VALUE_W-1:0] mag;
        logic [3:0]         digit [DIGITS_MAX];
        int                 nd;
        t_ascii_char        c;
        mag = value[VALUE_W-1] ? -value : value;
        nd  = 0;
        do begin
            digit[nd] = 4'(mag % 10);
            mag       = mag / 10;
            nd++;
        end while (mag != 0 && nd < DIGITS_MAX);
        if (value[VALUE_W-1]) begin
            c.code = CODE_MINUS;
            c.last = 1'b0;
            expected_chars.push_back(c);
        end
        for (int i = nd - 1; i >= 0; i--) begin
            c.code = CODE_ZERO + CHAR_W'(digit[i]);
            c.last = (i == 0);
            expected_chars.push_back(c);
        end
    endtask

    task automatic queue_typed_text(input string text);
        byte         b;
        t_ascii_char c;
        for (int i = 0; i < text.len(); i++) begin
            b      = text[i];
            c.code = b[CHAR_W-1:0];
            c.last = (i == text.len() - 1);
            expected_chars.push_back(c);
        end
    endtask

    task automatic send_value(input logic [VALUE_W-1:0] value, input string text);
        i_valid <= 1'b1;
        i_value <= value;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (text.len() == 0) begin
            queue_decimal_chars(value);
        end else begin
            queue_typed_text(text);
        end
        values_taken++;
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 120)) @(posedge i_clk);
            end else begin
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            burst_left = $urandom_range(0, 15);
        end else begin
            burst_left--;
        end
    endtask

    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] v;
        int                 k;
        case ($urandom_range(0, 5))
            0, 1: begin
                v = {$urandom, $urandom};
            end
            2: begin
                k = $urandom_range(1, DIGITS_MAX);
                v = {$urandom, $urandom} % power_of_ten(k);
                if ($urandom_range(0, 1)) v = -v;
            end
            3: begin
                k = $urandom_range(0, 18);
                v = power_of_ten(k) + VALUE_W'($urandom_range(0, 2)) - 64'd1;
                if ($urandom_range(0, 1)) v = -v;
            end
            4: begin
                v = VALUE_W'($urandom_range(0, 1000));
                if ($urandom_range(0, 1)) v = -v;
            end
            default: begin
                case ($urandom_range(0, 4))
                    0:       v = {1'b0, {(VALUE_W-1){1'b1}}};
                    1:       v = {1'b1, {(VALUE_W-1){1'b0}}};
                    2:       v = {1'b1, {(VALUE_W-2){1'b0}}, 1'b1};
                    3:       v = '0;
                    default: v = '1;
                endcase
            end
        endcase
        return v;
    endfunction

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // character checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected char %0d last %0b",
                                          o_char_code, o_last));
            end else begin
                want_char = expected_chars.pop_front();
                if (o_char_code !== want_char.code) begin
                    report_mismatch($sformatf("char_code %0d, want %0d",
                                              o_char_code, want_char.code));
                end
                if (o_last !== want_char.last) begin
                    report_mismatch($sformatf("last %0b, want %0b",
                                              o_last, want_char.last));
                end
            end
        end
    end

    // receiver stall patterns, plus one long hold-off
    initial begin
        int mode;
        int span;
        i_stall <= 1'b0;
        forever begin
            if (!long_hold_done && values_taken >= 30) begin
                i_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                long_hold_done = 1'b1;
            end
            mode = $urandom_range(0, 3);
            span = (mode == 3) ? $urandom_range(1, 15) : $urandom_range(5, 60);
            repeat (span) begin
                case (mode)
                    0:       i_stall <= 1'b0;
                    1:       i_stall <= ($urandom_range(0, 3) == 0);
                    2:       i_stall <= 1'($urandom_range(0, 1));
                    default: i_stall <= 1'b1;
                endcase
                @(posedge i_clk);
            end
        end
    end

    initial begin
        dir_value = '{
            64'd0, 64'd1, -64'sd1, 64'd9, 64'd10, -64'sd10, -64'sd100,
            64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000,
            64'h8000_0000_0000_0001,
            64'd99, 64'd100, 64'd999_999_999_999_999_999,
            64'd1_000_000_000_000_000_000, -64'sd1_000_000_000_000_000_000,
            64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
            64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555,
            64'd12345, -64'sd7, 64'd10_000_000_000_000_000_000
        };
        dir_text = '{
            "0", "1", "-1", "9", "10", "-10", "-100",
            "9223372036854775807", "-9223372036854775808",
            "-9223372036854775807",
            "", "", "", "", "", "", "", "", "", "", "", ""
        };
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_value <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_N; i++) begin
            send_value(dir_value[i], dir_text[i]);
        end
        for (int i = 0; i < RANDOM_VALUES; i++) begin
            send_value(random_value(), "");
        end
        i_valid <= 1'b0;

        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_chars.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
